@@ rtl/core/mses_pkg.sv @@
// Package for the millisecond event scheduler.
// Holds sizes, result kind codes and the controller/datapath command and status structs.
// No dependencies.
package mses_pkg;

   localparam int EVENT_SLOTS = 16;
   localparam int SLOT_BITS   = $clog2(EVENT_SLOTS);
   localparam int CNT_BITS    = $clog2(EVENT_SLOTS + 1);
   localparam int ID_BITS     = 8;
   localparam int DELAY_BITS  = 16;
   localparam int NOW_BITS    = 16;
   localparam int KIND_BITS   = 2;
   localparam int REQ_BITS    = 24;
   localparam int RSP_BITS    = 32;

   localparam logic [KIND_BITS-1:0] KIND_ACK  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIRE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd2;

   typedef struct packed {
      logic latch;
      logic load_ack;
      logic tick_start;
      logic rd_issue;
      logic keep_write;
      logic load_fire;
      logic load_done;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic scan_end;
      logic rem_zero;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/core/mses_ctrl.sv @@
// Controller state machine for the millisecond event scheduler.
// Depends on mses_pkg; drives commands to mses_dpath and reads its status.
module mses_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mses_pkg::stat_type stat,
   output mses_pkg::cmd_type  cmd
);
   import mses_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.action) begin
               if (stat.out_free) begin
                  cmd.load_ack = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.tick_start = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            if (stat.scan_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.rem_zero) begin
               if (stat.out_free) begin
                  cmd.load_fire = 1'b1;
                  state_in      = ST_READ;
               end
            end else begin
               cmd.keep_write = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/mses_dpath.sv @@
// Datapath for the millisecond event scheduler: slot memory, counters, result register.
// Depends on mses_pkg; controlled by mses_ctrl through cmd_type and stat_type.
module mses_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mses_pkg::REQ_BITS-1:0]       req_tdata,
   input  logic                                req_tuser,
   input  mses_pkg::cmd_type                   cmd,
   output mses_pkg::stat_type                  stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mses_pkg::RSP_BITS-1:0]       rsp_tdata,
   output logic [mses_pkg::KIND_BITS-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);
   import mses_pkg::*;

   logic [DELAY_BITS-1:0] rem_mem [EVENT_SLOTS];
   logic [ID_BITS-1:0]    evt_mem [EVENT_SLOTS];

   logic                  action_ff;
   logic [DELAY_BITS-1:0] delay_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [NOW_BITS-1:0]   now_ff, now_in;
   logic [CNT_BITS-1:0]   used_ff, used_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   keep_ff, keep_in;
   logic [DELAY_BITS-1:0] rd_rem_ff;
   logic [ID_BITS-1:0]    rd_evt_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [NOW_BITS-1:0]   rsp_now_ff, rsp_now_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  id_nonzero;
   logic                  table_full;
   logic                  store;
   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [DELAY_BITS-1:0] wr_rem;
   logic [ID_BITS-1:0]    wr_evt;
   logic                  load;

   assign id_nonzero = (id_ff != '0);
   assign table_full = (used_ff >= CNT_BITS'(EVENT_SLOTS));
   assign store      = cmd.load_ack && id_nonzero && !table_full;
   assign load       = cmd.load_ack || cmd.load_fire || cmd.load_done;

   assign stat.action   = action_ff;
   assign stat.scan_end = (idx_ff == used_ff);
   assign stat.rem_zero = (rd_rem_ff == '0);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr_en   = store || cmd.keep_write;
      wr_addr = store ? used_ff[SLOT_BITS-1:0] : keep_ff[SLOT_BITS-1:0];
      wr_rem  = store ? delay_ff : rd_rem_ff - DELAY_BITS'(1);
      wr_evt  = store ? id_ff : rd_evt_ff;
   end

   always_comb begin
      now_in  = now_ff;
      used_in = used_ff;
      idx_in  = idx_ff;
      keep_in = keep_ff;
      if (store) begin
         used_in = used_ff + CNT_BITS'(1);
      end
      if (cmd.tick_start) begin
         now_in  = now_ff + NOW_BITS'(1);
         idx_in  = '0;
         keep_in = '0;
      end
      if (cmd.rd_issue) begin
         idx_in = idx_ff + CNT_BITS'(1);
      end
      if (cmd.keep_write) begin
         keep_in = keep_ff + CNT_BITS'(1);
      end
      if (cmd.load_done) begin
         used_in = keep_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.load_ack && id_nonzero && table_full;
         rsp_id_in     = cmd.load_fire ? rd_evt_ff : '0;
         rsp_now_in    = now_ff;
         rsp_last_in   = !cmd.load_fire;
         if (cmd.load_ack) begin
            rsp_kind_in = KIND_ACK;
         end else if (cmd.load_fire) begin
            rsp_kind_in = KIND_FIRE;
         end else begin
            rsp_kind_in = KIND_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      keep_ff       <= keep_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.latch) begin
         action_ff <= req_tuser;
         delay_ff  <= req_tdata[DELAY_BITS-1:0];
         id_ff     <= req_tdata[DELAY_BITS +: ID_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rem_mem[wr_addr] <= wr_rem;
         evt_mem[wr_addr] <= wr_evt;
      end
      if (cmd.rd_issue) begin
         rd_rem_ff <= rem_mem[idx_ff[SLOT_BITS-1:0]];
         rd_evt_ff <= evt_mem[idx_ff[SLOT_BITS-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_BITS - 1 - ID_BITS - NOW_BITS)'(0), rsp_now_ff, rsp_id_ff,
                        rsp_status_ff};

endmodule

@@ rtl/core/ms_event_scheduler.sv @@
// Top level of the millisecond event scheduler.
// Depends on mses_pkg, mses_ctrl and mses_dpath.
//
// Channel  Direction  Beat contents
// req      in         tuser: action; tdata: delay_ms, event_id
// rsp      out        tuser: kind; tdata: status, fired_id, now_ms; tlast: last
//
// A schedule request is answered from the dispatch state before the next beat is accepted.
// The slot memory has a single read port; a tick reads it once per event and rewrites
// it for every event that stays.
// Reset clears the counter, the event count and the valid flag of the result register.
// A stalled result register holds the walk until the beat is taken.
module ms_event_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] delay_ms, [23:16] event_id
   input  logic [mses_pkg::REQ_BITS-1:0]      req_tdata,
   // [0] action
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] status, [8:1] fired_id, [24:9] now_ms, [31:25] zero
   output logic [mses_pkg::RSP_BITS-1:0]      rsp_tdata,
   // [1:0] kind
   output logic [mses_pkg::KIND_BITS-1:0]     rsp_tuser,
   output logic                               rsp_tlast
);
   import mses_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mses_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mses_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/ms_event_scheduler_tb.sv @@
// Testbench for ms_event_scheduler: drives schedule and tick beats and predicts every result beat.
// Checks each result beat against its prediction, including a full table.
// Depends on mses_pkg and the ms_event_scheduler RTL.
module ms_event_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mses_pkg::*;

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_SCHED = 1'b1;

   typedef struct {
      logic                  action;
      logic [DELAY_BITS-1:0] delay;
      logic [ID_BITS-1:0]    id;
      logic                  steady;
   } timer_req_type;

   typedef struct {
      logic [KIND_BITS-1:0] kind;
      logic                 status;
      logic [ID_BITS-1:0]   fired_id;
      logic [NOW_BITS-1:0]  now_ms;
      logic                 last;
   } timer_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_BITS-1:0]   req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic [KIND_BITS-1:0]  rsp_tuser;
   logic                  rsp_tlast;

   timer_req_type request_list[$];
   timer_rsp_type due_results[$];
   timer_req_type on_bus;

   logic [NOW_BITS-1:0]   timer_ms = '0;
   logic [DELAY_BITS-1:0] ev_left[EVENT_SLOTS];
   logic [ID_BITS-1:0]    ev_name[EVENT_SLOTS];
   int                    ev_count = 0;

   int mismatches = 0;
   int burst_left = 0;
   int gap_left   = 0;
   int stall_pct  = 0;
   int stall_left = 0;
   int mode_left  = 0;

   always #5 clock = ~clock;

   ms_event_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic add_schedule(input int delay, input int id, input logic steady = 1'b0);
      timer_req_type it;
      it.action = ACT_SCHED;
      it.delay  = delay[DELAY_BITS-1:0];
      it.id     = id[ID_BITS-1:0];
      it.steady = steady;
      request_list.push_back(it);
   endtask

   task automatic add_tick(input logic steady = 1'b0);
      timer_req_type it;
      it.action = ACT_TICK;
      it.delay  = DELAY_BITS'($urandom_range(0, 65535));
      it.id     = ID_BITS'($urandom_range(0, 255));
      it.steady = steady;
      request_list.push_back(it);
   endtask

   task automatic apply_to_timer(input timer_req_type it);
      timer_rsp_type b;
      int            keep;
      int            i;
      b.status   = 1'b0;
      b.fired_id = '0;
      if (it.action == ACT_SCHED) begin
         if (it.id != '0) begin
            if (ev_count >= EVENT_SLOTS) begin
               b.status = 1'b1;
            end else begin
               ev_left[ev_count] = it.delay;
               ev_name[ev_count] = it.id;
               ev_count++;
            end
         end
         b.kind   = KIND_ACK;
         b.now_ms = timer_ms;
         b.last   = 1'b1;
         due_results.push_back(b);
      end else begin
         timer_ms = timer_ms + 1'b1;
         keep = 0;
         for (i = 0; i < ev_count; i++) begin
            if (ev_left[i] == '0) begin
               b.kind     = KIND_FIRE;
               b.status   = 1'b0;
               b.fired_id = ev_name[i];
               b.now_ms   = timer_ms;
               b.last     = 1'b0;
               due_results.push_back(b);
            end else begin
               ev_left[keep] = ev_left[i] - 1'b1;
               ev_name[keep] = ev_name[i];
               keep++;
            end
         end
         ev_count   = keep;
         b.kind     = KIND_DONE;
         b.status   = 1'b0;
         b.fired_id = '0;
         b.now_ms   = timer_ms;
         b.last     = 1'b1;
         due_results.push_back(b);
      end
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_to_timer(on_bus);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_list.size() > 0) begin
               on_bus = request_list.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_bus.id, on_bus.delay};
               req_tuser  <= on_bus.action;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  if (on_bus.steady || $urandom_range(0, 3) == 0) begin
                     gap_left = 0;
                  end else begin
                     gap_left = $urandom_range(1, 40);
                  end
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      int mix[4] = '{0, 5, 20, 50};
      if (mode_left == 0) begin
         stall_pct = mix[$urandom_range(0, 3)];
         mode_left = $urandom_range(100, 400);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      timer_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $error("unexpected result beat: kind %0d, tdata 0x%08h", rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            e = due_results.pop_front();
            check_field("kind", e.kind, rsp_tuser);
            check_field("status", e.status, rsp_tdata[0]);
            check_field("fired_id", e.fired_id, rsp_tdata[8:1]);
            check_field("now_ms", e.now_ms, rsp_tdata[24:9]);
            check_field("pad", 0, rsp_tdata[31:25]);
            check_field("last", e.last, rsp_tlast);
         end
      end
   end

   initial begin
      int i;
      int seg;
      int k;
      int sched_pct;
      int mix[4] = '{30, 50, 70, 85};

      // Directed part: empty tick, no-event request, zero delay, ordering, full table.
      add_tick();
      add_schedule(16'h1234, 0);
      add_schedule(0, 8'hFF);
      add_tick();
      add_schedule(2, 8'h80);
      add_schedule(0, 8'h01);
      add_schedule(1, 8'h7F);
      add_tick();
      add_tick();
      add_tick();
      for (i = 1; i <= EVENT_SLOTS; i++) begin
         add_schedule(0, (i * 37) % 255 + 1);
      end
      add_schedule(5, 8'hAA);
      add_schedule(5, 0);
      add_tick();

      for (seg = 0; seg < 10; seg++) begin
         sched_pct = mix[$urandom_range(0, 3)];
         for (k = 0; k < 35; k++) begin
            if ($urandom_range(0, 99) < sched_pct) begin
               add_schedule(($urandom_range(0, 49) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 6),
                            ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 255));
            end else begin
               add_tick();
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (request_list.size() != 0 || req_tvalid || due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);

      if (mismatches == 0 && due_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
